FILE: hdl/smig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smig_pkg
// Shared constants for the sphere mesh index generator: field widths,
// segment register reset and the default segment limit.
// ----------------------------------------------------------------------------
package smig_pkg;

  localparam int MaxSegments = 32;   // default upper clamp for segments
  localparam int SegW        = 6;    // segments register width
  localparam int SegReset    = 8;    // segments after reset
  localparam int VtxW        = 11;   // vertex index field width
  localparam int FaceW       = 12;   // face number field width

endpackage

FILE: hdl/sphere_mesh_index_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_mesh_index_generator_unit
// Emits the triangle index list of a UV sphere, one triangle per transfer:
// top cap fan, bottom cap fan, then the bands between adjacent rings.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | restart_i
//   out     | output    | out_valid_o/out_stall_i | vertex_a/b/c_o, face_number_o,
//           |           |                         | last_face_o
//   cfg     | input     | cfg_we_i                | cfg_wdata_i (segments)
//
// One triangle per cycle while in_stall_o is low; a result appears in the cycle after its request is taken.
// The sequence counters act as the input register and the triangle is
// formed by adders between them and the result register.
// in_stall_o is high only while a result is held and out_stall_i is high.
// Reset and any segments write return the sequence to triangle 0.
// ----------------------------------------------------------------------------
module sphere_mesh_index_generator_unit #(
  parameter int MAX_SEGMENTS = smig_pkg::MaxSegments
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [smig_pkg::SegW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [smig_pkg::VtxW-1:0]  vertex_a_o,
  output logic [smig_pkg::VtxW-1:0]  vertex_b_o,
  output logic [smig_pkg::VtxW-1:0]  vertex_c_o,
  output logic [smig_pkg::FaceW-1:0] face_number_o,
  output logic                       last_face_o
);

  localparam int SW   = $clog2(MAX_SEGMENTS + 1);
  localparam int RW   = SW + 1;
  // step counter must also hold 2R for the band wrap compare
  localparam int KW   = $clog2(4 * MAX_SEGMENTS + 1);
  localparam int VNW  = $clog2(2 * MAX_SEGMENTS * (MAX_SEGMENTS - 1) + 3);
  localparam int VIW  = (VNW > smig_pkg::VtxW) ? VNW : smig_pkg::VtxW;
  localparam int FW   = smig_pkg::FaceW;

  localparam int RstS = (smig_pkg::SegReset > MAX_SEGMENTS) ? MAX_SEGMENTS
                                                            : smig_pkg::SegReset;
  localparam int RstR = 2 * RstS;
  localparam int RstV = RstR * (RstS - 1) + 2;

  localparam logic [1:0] PH_TOP    = 2'd0;
  localparam logic [1:0] PH_BOTTOM = 2'd1;
  localparam logic [1:0] PH_BAND   = 2'd2;

  // mesh geometry, derived once per segments write
  logic [SW-1:0]  seg_q, seg_d;
  logic [RW-1:0]  ring_q, ring_d;
  logic [VIW-1:0] vcnt_q, vcnt_d;

  // sequence state
  logic [1:0]     phase_q, phase_d;
  logic [SW-1:0]  band_q, band_d;
  logic [KW-1:0]  step_q, step_d;
  logic [VIW-1:0] base_q, base_d;
  logic [FW-1:0]  face_q, face_d;

  logic           out_valid_q;
  logic [VIW-1:0] a_q, b_q, c_q;
  logic [FW-1:0]  fnum_q;
  logic           last_q;

  logic           in_xfer;
  logic           restart_eff;
  logic [1:0]     ph;
  logic [SW-1:0]  band;
  logic [KW-1:0]  k;
  logic [VIW-1:0] base;
  logic [FW-1:0]  face;
  logic [VIW-1:0] a_d, b_d, c_d;
  logic           last_d;
  logic [VIW-1:0] r_x, k_x, m_x, fi, si;
  logic [KW-1:0]  k_next;
  logic [KW-1:0]  r_k, r2_k;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // clamp and derive geometry from the written value
  always_comb begin
    if (cfg_wdata_i < 2) begin
      seg_d = SW'(2);
    end else if (32'(cfg_wdata_i) > MAX_SEGMENTS) begin
      seg_d = SW'(MAX_SEGMENTS);
    end else begin
      seg_d = SW'(cfg_wdata_i);
    end
    ring_d = {seg_d, 1'b0};
    vcnt_d = VIW'(ring_d) * VIW'(seg_d - SW'(1)) + VIW'(2);
  end

  always_comb begin
    restart_eff = restart_i | (phase_q > PH_BAND);
    ph   = restart_eff ? PH_TOP : phase_q;
    band = restart_eff ? '0 : band_q;
    k    = restart_eff ? '0 : step_q;
    base = restart_eff ? '0 : base_q;
    face = restart_eff ? '0 : face_q;

    r_x  = VIW'(ring_q);
    k_x  = VIW'(k);
    m_x  = VIW'((k - KW'(2)) >> 1);
    fi   = base + m_x;
    si   = base + r_x + m_x;
    r_k  = KW'(ring_q);
    r2_k = KW'({ring_q, 1'b0});

    a_d    = '0;
    b_d    = '0;
    c_d    = '0;
    last_d = 1'b0;
    unique case (ph)
      PH_TOP: begin
        a_d = vcnt_q - VIW'(1);
        if (k == '0) begin
          b_d = r_x - VIW'(1);
          c_d = '0;
        end else begin
          b_d = k_x - VIW'(1);
          c_d = k_x;
        end
      end
      PH_BOTTOM: begin
        a_d = vcnt_q - VIW'(2);
        if (k == '0) begin
          b_d = vcnt_q - r_x - VIW'(2);
          c_d = vcnt_q - VIW'(3);
        end else begin
          b_d = vcnt_q - VIW'(2) - k_x;
          c_d = vcnt_q - VIW'(3) - k_x;
        end
        last_d = (seg_q == SW'(2)) && (k == r_k - KW'(1));
      end
      default: begin
        if (k == '0) begin
          a_d = base;
          b_d = base + r_x - VIW'(1);
          c_d = base + r_x;
        end else if (k == KW'(1)) begin
          a_d = base + r_x - VIW'(1);
          b_d = base + {r_x[VIW-2:0], 1'b0} - VIW'(1);
          c_d = base + r_x;
        end else if (!k[0]) begin
          a_d = fi;
          b_d = si;
          c_d = si + VIW'(1);
        end else begin
          a_d = fi;
          b_d = si + VIW'(1);
          c_d = fi + VIW'(1);
        end
        last_d = (k == r2_k - KW'(1)) && ((RW'(band) + RW'(3)) >= RW'(seg_q));
      end
    endcase
  end

  // sequence advance
  always_comb begin
    k_next  = k + KW'(1);
    phase_d = ph;
    band_d  = band;
    step_d  = k_next;
    base_d  = base;
    face_d  = face + FW'(1);
    if (last_d) begin
      phase_d = PH_TOP;
      band_d  = '0;
      step_d  = '0;
      base_d  = '0;
      face_d  = '0;
    end else begin
      unique case (ph)
        PH_TOP: begin
          if (k_next >= r_k) begin
            step_d  = '0;
            phase_d = PH_BOTTOM;
          end
        end
        PH_BOTTOM: begin
          if (k_next >= r_k) begin
            step_d  = '0;
            phase_d = PH_BAND;
            band_d  = '0;
            base_d  = '0;
          end
        end
        default: begin
          if (k_next >= r2_k) begin
            step_d = '0;
            band_d = band + SW'(1);
            base_d = base + r_x;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= SW'(RstS);
      ring_q  <= RW'(RstR);
      vcnt_q  <= VIW'(RstV);
      phase_q <= PH_TOP;
      band_q  <= '0;
      step_q  <= '0;
      base_q  <= '0;
      face_q  <= '0;
    end else if (cfg_we_i) begin
      seg_q   <= seg_d;
      ring_q  <= ring_d;
      vcnt_q  <= vcnt_d;
      phase_q <= PH_TOP;
      band_q  <= '0;
      step_q  <= '0;
      base_q  <= '0;
      face_q  <= '0;
    end else if (in_xfer) begin
      phase_q <= phase_d;
      band_q  <= band_d;
      step_q  <= step_d;
      base_q  <= base_d;
      face_q  <= face_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_q    <= a_d;
      b_q    <= b_d;
      c_q    <= c_d;
      fnum_q <= face;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vertex_a_o    = a_q[smig_pkg::VtxW-1:0];
  assign vertex_b_o    = b_q[smig_pkg::VtxW-1:0];
  assign vertex_c_o    = c_q[smig_pkg::VtxW-1:0];
  assign face_number_o = fnum_q;
  assign last_face_o   = last_q;

endmodule
